// ===== design/tle_pkg.sv =====
// Shared constants, codes and control types of the terminal line editor.
package tle_pkg;

  localparam int unsigned LINE_MAX  = 32;
  localparam int unsigned ADDR_W    = $clog2(LINE_MAX);
  localparam int unsigned LEN_W     = $clog2(LINE_MAX + 1);
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [BYTE_W-1:0] CH_TAB          = 8'h09;
  localparam logic [BYTE_W-1:0] CH_HELP         = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_BS           = 8'h08;
  localparam logic [BYTE_W-1:0] CH_CR           = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NL           = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE        = 8'h20;
  localparam logic [BYTE_W-1:0] HIST_UP_RESET   = 8'd82;
  localparam logic [BYTE_W-1:0] HIST_DOWN_RESET = 8'd81;

  localparam logic [CFG_IDX_W-1:0] REG_HIST_UP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_DOWN = 8'd1;

  localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    KEY_TERM,
    KEY_HIST,
    KEY_BACK,
    KEY_ENTER,
    KEY_PLAIN
  } key_cls_e;

  typedef enum logic [2:0] {
    OSEL_NEWLINE,
    OSEL_RX,
    OSEL_SPACE,
    OSEL_LINE,
    OSEL_EMPTY
  } out_sel_e;

  typedef struct packed {
    logic     load_byte;
    logic     append;
    logic     len_dec;
    logic     len_clear;
    logic     idx_clear;
    logic     idx_step;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    key_cls_e key_cls;
    logic     len_zero;
    logic     full_next;
    logic     idx_last;
    logic     out_free;
  } dp_sts_t;

endpackage

// ===== design/tle_in_if.sv =====
// Input channel carrying one received byte per item.
interface tle_in_if;
  logic                        valid;
  logic                        ready;
  logic [tle_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/tle_out_if.sv =====
// Result channel carrying echo bytes, line bytes and empty-line markers.
interface tle_out_if;
  logic                        valid;
  logic                        ready;
  logic [tle_pkg::KIND_W-1:0]  kind;
  logic [tle_pkg::BYTE_W-1:0]  data_byte;
  logic                        run_last;

  modport source (output valid, output kind, output data_byte, output run_last, input ready);
  modport sink (input valid, input kind, input data_byte, input run_last, output ready);
endinterface

// ===== design/tle_cfg_if.sv =====
// Configuration write channel carrying a register index and write data.
interface tle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tle_pkg::CFG_IDX_W-1:0] index;
  logic [tle_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/terminal_line_editor_core.sv =====
// Top level of the terminal line editor: controller, datapath and channel hookup.
// Each received byte is taken as one item and handled to completion before the next is
// accepted. A plain byte is classified, echoed and appended; backspace shortens the
// line and echoes backspace, space and backspace; backspace on an empty line gives no
// result. A line is delivered byte by byte after enter, or after a key that appends;
// results leave at one per cycle while the receiver is ready, through a single result
// register, fed by the one read port of the line store. A finished result may wait in
// that register while the next item is accepted. The history key registers may be written
// at any time the block is idle; indexes other than the two registers are ignored.
module terminal_line_editor_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tle_in_if.sink    rx_i,
  tle_out_if.source res_o,
  tle_cfg_if.sink   cfg_i
);
  import tle_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign rx_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tle_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_kind_o  (res_o.kind),
    .res_data_o  (res_o.data_byte),
    .res_last_o  (res_o.run_last)
  );

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("Result register loaded while a result was still pending.");

  a_back_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.len_dec |-> !sts.len_zero)
    else $error("Backspace removed a byte from an empty line.");

  a_append_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.append && sts.full_next) |=> sts.key_cls != KEY_BACK && !in_ready)
    else $error("Full line was not delivered after the append.");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_EMPTY) |-> (res_o.data_byte == '0 && res_o.run_last))
    else $error("Empty-line marker carries data or is not the last result.");

endmodule

// ===== design/tle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tle_datapath.sv =====
// Datapath: key registers, line store, fill count, read index and result register.
module tle_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tle_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tle_pkg::BYTE_W-1:0]    cfg_data_i,
  input  tle_pkg::dp_cmd_t              cmd_i,
  output tle_pkg::dp_sts_t              sts_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [tle_pkg::KIND_W-1:0]    res_kind_o,
  output logic [tle_pkg::BYTE_W-1:0]    res_data_o,
  output logic                          res_last_o
);
  import tle_pkg::*;

  logic [BYTE_W-1:0] rx_q;
  logic [BYTE_W-1:0] hist_up_q;
  logic [BYTE_W-1:0] hist_dn_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic              out_last_q;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  key_cls_e          key_cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_up_q <= HIST_UP_RESET;
      hist_dn_q <= HIST_DOWN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_HIST_UP) begin
        hist_up_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_HIST_DOWN) begin
        hist_dn_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      rx_q <= rx_byte_i;
    end
  end

  // The key order resolves clashes when a history register holds another key's code.
  always_comb begin
    priority if (rx_q == CH_TAB || rx_q == CH_HELP) begin
      key_cls = KEY_TERM;
    end else if (rx_q == hist_up_q || rx_q == hist_dn_q) begin
      key_cls = KEY_HIST;
    end else if (rx_q == CH_BS) begin
      key_cls = KEY_BACK;
    end else if (rx_q == CH_CR) begin
      key_cls = KEY_ENTER;
    end else begin
      key_cls = KEY_PLAIN;
    end
  end

  always_comb begin
    len_d = len_q;
    priority if (cmd_i.append) begin
      len_d = len_q + LEN_W'(1);
    end else if (cmd_i.len_dec) begin
      len_d = len_q - LEN_W'(1);
    end else if (cmd_i.len_clear) begin
      len_d = '0;
    end
  end

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_step) begin
      idx_d = ADDR_W'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  assign ram_re    = cmd_i.idx_clear | cmd_i.idx_step;
  assign ram_raddr = idx_d;

  tle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (rx_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (cmd_i.out_sel)
      OSEL_NEWLINE: begin
        out_kind_d = KIND_ECHO;
        out_data_d = CH_NL;
      end
      OSEL_RX: begin
        out_kind_d = KIND_ECHO;
        out_data_d = rx_q;
      end
      OSEL_SPACE: begin
        out_kind_d = KIND_ECHO;
        out_data_d = CH_SPACE;
      end
      OSEL_LINE: begin
        out_kind_d = KIND_LINE;
        out_data_d = ram_rdata;
      end
      OSEL_EMPTY: begin
        out_kind_d = KIND_EMPTY;
        out_data_d = '0;
      end
      default: begin
        out_kind_d = KIND_ECHO;
        out_data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= out_kind_d;
      out_data_q <= out_data_d;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.key_cls   = key_cls;
  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.full_next = (len_q == LEN_W'(LINE_MAX - 1));
  assign sts_o.idx_last  = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
  assign sts_o.out_free  = ~out_valid_q | res_ready_i;

  assign res_valid_o = out_valid_q;
  assign res_kind_o  = out_kind_q;
  assign res_data_o  = out_data_q;
  assign res_last_o  = out_last_q;

endmodule

// ===== design/tle_ctrl.sv =====
// Controller: sequences echo, append, backspace and line delivery for each item.
module tle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tle_pkg::dp_sts_t sts_i,
  output tle_pkg::dp_cmd_t cmd_o
);
  import tle_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_ECHO_NL  = 4'd2;
  localparam logic [3:0] S_ECHO_RX  = 4'd3;
  localparam logic [3:0] S_APPEND   = 4'd4;
  localparam logic [3:0] S_PREP     = 4'd5;
  localparam logic [3:0] S_DELIVER  = 4'd6;
  localparam logic [3:0] S_EMPTY    = 4'd7;
  localparam logic [3:0] S_BACK1    = 4'd8;
  localparam logic [3:0] S_BACK2    = 4'd9;
  localparam logic [3:0] S_BACK3    = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_sel = OSEL_NEWLINE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.key_cls)
          KEY_TERM, KEY_ENTER: state_d = S_ECHO_NL;
          KEY_HIST:            state_d = S_APPEND;
          KEY_BACK: begin
            if (sts_i.len_zero) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.len_dec = 1'b1;
              state_d       = S_BACK1;
            end
          end
          KEY_PLAIN:           state_d = S_ECHO_RX;
          default:             state_d = S_IDLE;
        endcase
      end
      S_ECHO_NL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_NEWLINE;
          state_d        = (sts_i.key_cls == KEY_ENTER) ? S_PREP : S_APPEND;
        end
      end
      S_ECHO_RX: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_RX;
          cmd_o.out_last = ~sts_i.full_next;
          state_d        = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        if (sts_i.key_cls == KEY_PLAIN && !sts_i.full_next) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (sts_i.len_zero) begin
          state_d = S_EMPTY;
        end else begin
          cmd_o.idx_clear = 1'b1;
          state_d         = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_LINE;
          cmd_o.out_last = sts_i.idx_last;
          if (sts_i.idx_last) begin
            cmd_o.len_clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.idx_step = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = OSEL_EMPTY;
          cmd_o.out_last  = 1'b1;
          cmd_o.len_clear = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_BACK1: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_RX;
          state_d        = S_BACK2;
        end
      end
      S_BACK2: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_SPACE;
          state_d        = S_BACK3;
        end
      end
      S_BACK3: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_RX;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
